[rtl/rfpp_pkg.sv]
package rfpp_pkg;

    localparam logic [3:0] FMT_R4G4          = 4'd0;
    localparam logic [3:0] FMT_R4G4B4A4      = 4'd1;
    localparam logic [3:0] FMT_B4G4R4A4      = 4'd2;
    localparam logic [3:0] FMT_R5G6B5        = 4'd3;
    localparam logic [3:0] FMT_B5G6R5        = 4'd4;
    localparam logic [3:0] FMT_R5G5B5A1      = 4'd5;
    localparam logic [3:0] FMT_B5G5R5A1      = 4'd6;
    localparam logic [3:0] FMT_A1R5G5B5      = 4'd7;
    localparam logic [3:0] FMT_B8G8R8        = 4'd8;
    localparam logic [3:0] FMT_B8G8R8A8      = 4'd9;
    localparam logic [3:0] FMT_A8B8G8R8      = 4'd10;
    localparam logic [3:0] FMT_A2R10G10B10_U = 4'd11;
    localparam logic [3:0] FMT_A2R10G10B10_I = 4'd12;
    localparam logic [3:0] FMT_A2B10G10R10_U = 4'd13;
    localparam logic [3:0] FMT_A2B10G10R10_I = 4'd14;

    localparam int NUM_LANES = 4;
    localparam int CODE_W    = 10;
    localparam int PROD_W    = 34;

    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam logic [31:0] U1023_BITS = 32'h447F_C000;
    localparam logic [31:0] U3_BITS   = 32'h4040_0000;

    typedef struct packed {
        logic [CODE_W-1:0] maxv;
        logic [CODE_W-1:0] mult;
        logic [31:0]       thresh;
    } lane_cfg_t;

    typedef lane_cfg_t [NUM_LANES-1:0] lane_cfg_arr_t;
    typedef logic [NUM_LANES-1:0][CODE_W-1:0] code_arr_t;

    function automatic lane_cfg_t unorm_cfg(input logic [CODE_W-1:0] maxv);
        lane_cfg_t c;
        c.maxv   = maxv;
        c.mult   = maxv;
        c.thresh = ONE_BITS;
        return c;
    endfunction

    function automatic lane_cfg_t uint_cfg(input logic [CODE_W-1:0] maxv,
                                           input logic [31:0] thresh);
        lane_cfg_t c;
        c.maxv   = maxv;
        c.mult   = CODE_W'(1);
        c.thresh = thresh;
        return c;
    endfunction

    // lane order: 0 red, 1 green, 2 blue, 3 alpha
    function automatic lane_cfg_arr_t fmt_cfg(input logic [3:0] fmt);
        lane_cfg_arr_t c;
        case (fmt)
            FMT_R4G4, FMT_R4G4B4A4, FMT_B4G4R4A4: begin
                for (int i = 0; i < NUM_LANES; i++) c[i] = unorm_cfg(10'h00F);
            end
            FMT_R5G6B5, FMT_B5G6R5: begin
                c[0] = unorm_cfg(10'h01F);
                c[1] = unorm_cfg(10'h03F);
                c[2] = unorm_cfg(10'h01F);
                c[3] = unorm_cfg(10'h001);
            end
            FMT_R5G5B5A1, FMT_B5G5R5A1, FMT_A1R5G5B5: begin
                c[0] = unorm_cfg(10'h01F);
                c[1] = unorm_cfg(10'h01F);
                c[2] = unorm_cfg(10'h01F);
                c[3] = unorm_cfg(10'h001);
            end
            FMT_B8G8R8, FMT_B8G8R8A8, FMT_A8B8G8R8: begin
                for (int i = 0; i < NUM_LANES; i++) c[i] = unorm_cfg(10'h0FF);
            end
            FMT_A2R10G10B10_U, FMT_A2B10G10R10_U: begin
                c[0] = unorm_cfg(10'h3FF);
                c[1] = unorm_cfg(10'h3FF);
                c[2] = unorm_cfg(10'h3FF);
                c[3] = unorm_cfg(10'h003);
            end
            FMT_A2R10G10B10_I, FMT_A2B10G10R10_I: begin
                c[0] = uint_cfg(10'h3FF, U1023_BITS);
                c[1] = uint_cfg(10'h3FF, U1023_BITS);
                c[2] = uint_cfg(10'h3FF, U1023_BITS);
                c[3] = uint_cfg(10'h003, U3_BITS);
            end
            default: begin
                for (int i = 0; i < NUM_LANES; i++) c[i] = unorm_cfg(10'h000);
            end
        endcase
        return c;
    endfunction

endpackage

[rtl/rgba_float_pixel_packer.sv]
// Pipeline: input transaction to result valid through the multiply stage, then the round stage.
// Throughput: one pixel per cycle when unstalled; four channel lanes, both stages fully pipelined.
// Backpressure holds stage two; stage one still accepts while empty. Ready follows the output stage.
// Reset: aresetn synchronous active low; clears stage valids and fmt_reg to R4G4.
// Pipeline data registers are not reset.
module rgba_float_pixel_packer
    import rfpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_red_bits,
    input  logic [31:0] s_green_bits,
    input  logic [31:0] s_blue_bits,
    input  logic [31:0] s_alpha_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_packed_pixel,
    output logic [2:0]  m_byte_count
);

    logic [3:0]    fmt_reg;
    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic          en1, en2;
    lane_cfg_arr_t cfg;
    code_arr_t     codes;
    logic [31:0]   lane_in [NUM_LANES];

    assign en2     = !v2_reg || m_ready;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign v1_next = en1 ? s_valid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign cfg     = fmt_cfg(fmt_reg);

    assign lane_in[0] = s_red_bits;
    assign lane_in[1] = s_green_bits;
    assign lane_in[2] = s_blue_bits;
    assign lane_in[3] = s_alpha_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_R4G4;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end else begin
            if (cfg_we) fmt_reg <= cfg_wdata;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        rfpp_lane u_lane (
            .aclk    (aclk),
            .en1     (en1),
            .en2     (en2),
            .bits_in (lane_in[i]),
            .cfg     (cfg[i]),
            .code    (codes[i])
        );
    end

    rfpp_merge u_merge (
        .fmt          (fmt_reg),
        .codes        (codes),
        .packed_pixel (m_packed_pixel),
        .byte_count   (m_byte_count)
    );

    assign m_valid = v2_reg;

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_count != 3'd0))
        else $error("zero byte count");
    a_r4g4_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && fmt_reg == FMT_R4G4) |-> (m_packed_pixel[31:8] == 24'd0))
        else $error("R4G4 high bits set");
    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && !m_ready) |=> v1_reg)
        else $error("stage one lost a transaction");
`endif

endmodule

[rtl/rfpp_lane.sv]
module rfpp_lane
    import rfpp_pkg::*;
(
    input  logic              aclk,
    input  logic              en1,
    input  logic              en2,
    input  logic [31:0]       bits_in,
    input  lane_cfg_t         cfg,
    output logic [CODE_W-1:0] code
);

    logic              zero_reg, zero_next;
    logic              sat_reg, sat_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [7:0]        shift_reg, shift_next;
    logic [CODE_W-1:0] maxv_reg;
    logic [CODE_W-1:0] code_reg, code_next;

    logic        is_nan;
    logic [7:0]  exp_eff;
    logic [23:0] mant;

    always_comb begin
        is_nan    = (bits_in[30:23] == 8'hFF) && (bits_in[22:0] != 23'd0);
        zero_next = is_nan || bits_in[31] || (bits_in == 32'd0);
        sat_next  = !zero_next && (bits_in >= cfg.thresh);
        exp_eff   = (bits_in[30:23] == 8'd0) ? 8'd1 : bits_in[30:23];
        mant      = {(bits_in[30:23] != 8'd0), bits_in[22:0]};
        prod_next = PROD_W'(mant) * PROD_W'(cfg.mult);
        shift_next = 8'd150 - exp_eff;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            zero_reg  <= zero_next;
            sat_reg   <= sat_next;
            prod_reg  <= prod_next;
            shift_reg <= shift_next;
            maxv_reg  <= cfg.maxv;
        end
    end

    // round product to 24 significant bits (nearest even), then half away to integer
    logic [5:0]        lead;
    logic [3:0]        drop;
    logic [PROD_W-1:0] mask;
    logic [PROD_W-1:0] half_ulp;
    logic              guard, sticky, lsb, rnd_up;
    logic [PROD_W:0]   rounded;
    logic [PROD_W+1:0] scaled;
    logic [CODE_W-1:0] int_code;

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < PROD_W; i++) begin
            if (prod_reg[i]) lead = 6'(i);
        end
        drop     = (lead > 6'd23) ? 4'(lead - 6'd23) : 4'd0;
        mask     = (PROD_W'(1) << drop) - PROD_W'(1);
        half_ulp = (drop == 4'd0) ? '0 : (PROD_W'(1) << (drop - 4'd1));
        guard    = (prod_reg & half_ulp) != '0;
        sticky   = (prod_reg & mask & ~half_ulp) != '0;
        lsb      = ((prod_reg >> drop) & PROD_W'(1)) != '0;
        rnd_up   = guard && (sticky || lsb);
        rounded  = {1'b0, prod_reg & ~mask} + (rnd_up ? ((PROD_W+1)'(1) << drop) : '0);
        scaled   = {rounded, 1'b0} >> shift_reg;
        int_code = CODE_W'(scaled[PROD_W+1:1]) + CODE_W'(scaled[0]);
        if (zero_reg) begin
            code_next = '0;
        end else if (sat_reg) begin
            code_next = maxv_reg;
        end else begin
            code_next = int_code & maxv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            code_reg <= code_next;
        end
    end

    assign code = code_reg;

endmodule

[rtl/rfpp_merge.sv]
module rfpp_merge
    import rfpp_pkg::*;
(
    input  logic [3:0]  fmt,
    input  code_arr_t   codes,
    output logic [31:0] packed_pixel,
    output logic [2:0]  byte_count
);

    logic [31:0] r, g, b, a;

    always_comb begin
        r = 32'(codes[0]);
        g = 32'(codes[1]);
        b = 32'(codes[2]);
        a = 32'(codes[3]);
        byte_count = 3'd4;
        case (fmt)
            FMT_R4G4: begin
                packed_pixel = g | (r << 4);
                byte_count   = 3'd1;
            end
            FMT_R4G4B4A4: begin
                packed_pixel = a | (b << 4) | (g << 8) | (r << 12);
                byte_count   = 3'd2;
            end
            FMT_B4G4R4A4: begin
                packed_pixel = a | (r << 4) | (g << 8) | (b << 12);
                byte_count   = 3'd2;
            end
            FMT_R5G6B5: begin
                packed_pixel = b | (g << 5) | (r << 11);
                byte_count   = 3'd2;
            end
            FMT_B5G6R5: begin
                packed_pixel = r | (g << 5) | (b << 11);
                byte_count   = 3'd2;
            end
            FMT_R5G5B5A1: begin
                packed_pixel = a | (b << 1) | (g << 6) | (r << 11);
                byte_count   = 3'd2;
            end
            FMT_B5G5R5A1: begin
                packed_pixel = a | (r << 1) | (g << 6) | (b << 11);
                byte_count   = 3'd2;
            end
            FMT_A1R5G5B5: begin
                packed_pixel = b | (g << 5) | (r << 10) | (a << 15);
                byte_count   = 3'd2;
            end
            FMT_B8G8R8: begin
                packed_pixel = b | (g << 8) | (r << 16);
                byte_count   = 3'd3;
            end
            FMT_B8G8R8A8: packed_pixel = b | (g << 8) | (r << 16) | (a << 24);
            FMT_A8B8G8R8: packed_pixel = a | (b << 8) | (g << 16) | (r << 24);
            FMT_A2R10G10B10_U, FMT_A2R10G10B10_I:
                packed_pixel = b | (g << 10) | (r << 20) | (a << 30);
            FMT_A2B10G10R10_U, FMT_A2B10G10R10_I:
                packed_pixel = r | (g << 10) | (b << 20) | (a << 30);
            default: packed_pixel = 32'd0;
        endcase
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rfpp_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_red_bits = '0;
    logic [31:0] s_green_bits = '0;
    logic [31:0] s_blue_bits = '0;
    logic [31:0] s_alpha_bits = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_packed_pixel;
    logic [2:0]  m_byte_count;

    localparam logic [31:0] NAN_BITS  = 32'h7FC0_0000;
    localparam logic [31:0] PINF_BITS = 32'h7F80_0000;
    localparam logic [31:0] NINF_BITS = 32'hFF80_0000;
    localparam logic [31:0] HALF_BITS = 32'h3F00_0000;
    localparam int          NUM_RANDOM = 1830;

    typedef struct {
        logic [3:0]  fmt;
        logic [31:0] r, g, b, a;
        bit          fixed;
        logic [31:0] word;
        logic [2:0]  count;
    } pixel_row_t;

    logic [31:0] expected_words[$];
    logic [2:0]  expected_counts[$];
    logic [3:0]  cur_fmt = FMT_R4G4;
    int          mismatches = 0;
    bit          sender_done = 1'b0;

    rgba_float_pixel_packer DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red_bits     (s_red_bits),
        .s_green_bits   (s_green_bits),
        .s_blue_bits    (s_blue_bits),
        .s_alpha_bits   (s_alpha_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_packed_pixel (m_packed_pixel),
        .m_byte_count   (m_byte_count)
    );

    always #2 aclk = ~aclk;

    // exact single-precision scale and round half away from zero
    function automatic logic [9:0] channel_code(input logic [31:0] bits,
                                                input logic [9:0] maxv,
                                                input bit integer_lane);
        logic [31:0] limit;
        logic [63:0] m, prod, rnd, rem, half, v;
        int e, msb, s, k;
        if (bits[30:23] == 8'hFF && bits[22:0] != 0) return '0;
        if (bits[31] || bits[30:0] == 0) return '0;
        limit = integer_lane ? ((maxv == 10'h003) ? U3_BITS : U1023_BITS) : ONE_BITS;
        if (bits >= limit) return maxv;
        if (bits[30:23] == 0) begin
            m = {41'd0, bits[22:0]};
            e = -149;
        end else begin
            m = {40'd0, 1'b1, bits[22:0]};
            e = int'(bits[30:23]) - 150;
        end
        prod = m * (integer_lane ? 64'd1 : {54'd0, maxv});
        msb = 0;
        for (int i = 0; i < 64; i++) if (prod[i]) msb = i;
        s = 0;
        if (msb > 23) begin
            s = msb - 23;
            rnd = prod >> s;
            rem = prod & ((64'd1 << s) - 1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && rnd[0])) rnd++;
            prod = rnd;
        end
        k = e + s;
        if (k >= 0) v = prod << k;
        else if (-k > 62) v = '0;
        else v = (prod + (64'd1 << (-k - 1))) >> (-k);
        return v[9:0] & maxv;
    endfunction

    function automatic void pack_pixel(input logic [3:0] fmt, input logic [31:0] rb,
                                       input logic [31:0] gb, input logic [31:0] bb,
                                       input logic [31:0] ab, output logic [31:0] word,
                                       output logic [2:0] count);
        logic [31:0] r, g, b, a;
        word = '0;
        count = 3'd4;
        case (fmt)
            FMT_R4G4: begin
                r = 32'(channel_code(rb, 10'hF, 1'b0));
                g = 32'(channel_code(gb, 10'hF, 1'b0));
                word = g | (r << 4);
                count = 3'd1;
            end
            FMT_R4G4B4A4, FMT_B4G4R4A4: begin
                r = 32'(channel_code(rb, 10'hF, 1'b0));
                g = 32'(channel_code(gb, 10'hF, 1'b0));
                b = 32'(channel_code(bb, 10'hF, 1'b0));
                a = 32'(channel_code(ab, 10'hF, 1'b0));
                if (fmt == FMT_R4G4B4A4) word = a | (b << 4) | (g << 8) | (r << 12);
                else word = a | (r << 4) | (g << 8) | (b << 12);
                count = 3'd2;
            end
            FMT_R5G6B5, FMT_B5G6R5: begin
                r = 32'(channel_code(rb, 10'h1F, 1'b0));
                g = 32'(channel_code(gb, 10'h3F, 1'b0));
                b = 32'(channel_code(bb, 10'h1F, 1'b0));
                if (fmt == FMT_R5G6B5) word = b | (g << 5) | (r << 11);
                else word = r | (g << 5) | (b << 11);
                count = 3'd2;
            end
            FMT_R5G5B5A1, FMT_B5G5R5A1, FMT_A1R5G5B5: begin
                r = 32'(channel_code(rb, 10'h1F, 1'b0));
                g = 32'(channel_code(gb, 10'h1F, 1'b0));
                b = 32'(channel_code(bb, 10'h1F, 1'b0));
                a = 32'(channel_code(ab, 10'h1, 1'b0));
                if (fmt == FMT_R5G5B5A1) word = a | (b << 1) | (g << 6) | (r << 11);
                else if (fmt == FMT_B5G5R5A1) word = a | (r << 1) | (g << 6) | (b << 11);
                else word = b | (g << 5) | (r << 10) | (a << 15);
                count = 3'd2;
            end
            FMT_B8G8R8, FMT_B8G8R8A8, FMT_A8B8G8R8: begin
                r = 32'(channel_code(rb, 10'hFF, 1'b0));
                g = 32'(channel_code(gb, 10'hFF, 1'b0));
                b = 32'(channel_code(bb, 10'hFF, 1'b0));
                a = 32'(channel_code(ab, 10'hFF, 1'b0));
                if (fmt == FMT_B8G8R8) begin
                    word = b | (g << 8) | (r << 16);
                    count = 3'd3;
                end else if (fmt == FMT_B8G8R8A8) begin
                    word = b | (g << 8) | (r << 16) | (a << 24);
                end else begin
                    word = a | (b << 8) | (g << 16) | (r << 24);
                end
            end
            FMT_A2R10G10B10_U, FMT_A2B10G10R10_U, FMT_A2R10G10B10_I, FMT_A2B10G10R10_I: begin
                r = 32'(channel_code(rb, 10'h3FF, fmt[0] == 1'b0));
                g = 32'(channel_code(gb, 10'h3FF, fmt[0] == 1'b0));
                b = 32'(channel_code(bb, 10'h3FF, fmt[0] == 1'b0));
                a = 32'(channel_code(ab, 10'h3, fmt[0] == 1'b0));
                if (fmt == FMT_A2R10G10B10_U || fmt == FMT_A2R10G10B10_I)
                    word = b | (g << 10) | (r << 20) | (a << 30);
                else
                    word = r | (g << 10) | (b << 20) | (a << 30);
            end
            default: begin
                word = '0;
                count = 3'd4;
            end
        endcase
    endfunction

    function automatic logic [31:0] random_channel();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 32'h3F80_0000);
            4: return $urandom_range(0, 32'h4480_0000);
            5: return $urandom_range(32'h3F7F_F000, 32'h3F80_0010);
            6: return $urandom_range(0, 32'h0080_0000);
            7: begin
                case ($urandom_range(0, 6))
                    0: return NAN_BITS;
                    1: return PINF_BITS;
                    2: return NINF_BITS;
                    3: return 32'h8000_0000;
                    4: return HALF_BITS;
                    5: return 32'hFFFF_FFFF;
                    default: return 32'h7F80_0001;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_format(input logic [3:0] fmt);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_fmt = fmt;
    endtask

    task automatic send_pixel(input logic [31:0] rb, input logic [31:0] gb,
                              input logic [31:0] bb, input logic [31:0] ab,
                              input bit fixed, input logic [31:0] fword,
                              input logic [2:0] fcount, input bit burst);
        int gap;
        logic [31:0] word;
        logic [2:0] count;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red_bits <= rb;
        s_green_bits <= gb;
        s_blue_bits <= bb;
        s_alpha_bits <= ab;
        do @(posedge aclk); while (!s_ready);
        if (fixed) begin
            word = fword;
            count = fcount;
        end else begin
            pack_pixel(cur_fmt, rb, gb, bb, ab, word, count);
        end
        expected_words.push_back(word);
        expected_counts.push_back(count);
    endtask

    pixel_row_t directed[] = '{
        '{FMT_R4G4, ONE_BITS, ONE_BITS, ONE_BITS, ONE_BITS, 1, 32'h0000_00FF, 3'd1},
        '{FMT_R4G4, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 1, 32'h0, 3'd1},
        '{FMT_R4G4, NAN_BITS, NINF_BITS, NAN_BITS, NAN_BITS, 1, 32'h0, 3'd1},
        '{FMT_R4G4, PINF_BITS, HALF_BITS, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0},
        '{FMT_R4G4B4A4, ONE_BITS, ONE_BITS, ONE_BITS, ONE_BITS, 1, 32'h0000_FFFF, 3'd2},
        '{FMT_B4G4R4A4, HALF_BITS, 32'h3E80_0000, 32'h3F40_0000, 32'h3F7F_FFFF, 0, 0, 0},
        '{FMT_R5G6B5, PINF_BITS, PINF_BITS, PINF_BITS, 32'h0, 1, 32'h0000_FFFF, 3'd2},
        '{FMT_B5G6R5, HALF_BITS, 32'h3E00_0000, 32'h007F_FFFF, NAN_BITS, 0, 0, 0},
        '{FMT_R5G5B5A1, ONE_BITS, 32'h0, ONE_BITS, HALF_BITS, 0, 0, 0},
        '{FMT_B5G5R5A1, 32'h0, ONE_BITS, 32'h0, 32'h3EFF_FFFF, 0, 0, 0},
        '{FMT_A1R5G5B5, ONE_BITS, ONE_BITS, ONE_BITS, ONE_BITS, 1, 32'h0000_FFFF, 3'd2},
        '{FMT_B8G8R8, ONE_BITS, ONE_BITS, ONE_BITS, ONE_BITS, 1, 32'h00FF_FFFF, 3'd3},
        '{FMT_B8G8R8A8, PINF_BITS, PINF_BITS, PINF_BITS, PINF_BITS, 1, 32'hFFFF_FFFF, 3'd4},
        '{FMT_A8B8G8R8, HALF_BITS, 32'h3C00_0000, 32'h3B80_0000, 32'h3F7E_0000, 0, 0, 0},
        '{FMT_A2R10G10B10_U, ONE_BITS, 32'h0, NAN_BITS, ONE_BITS, 1, 32'hFFF0_0000, 3'd4},
        '{FMT_A2R10G10B10_U, HALF_BITS, 32'h3A80_0000, 32'h3F00_0001, HALF_BITS, 0, 0, 0},
        '{FMT_A2R10G10B10_I, 32'h447F_A000, 32'h4420_0000, 32'h3FC0_0000, 32'h4020_0000,
          0, 0, 0},
        '{FMT_A2B10G10R10_U, 32'h3F7F_FFFF, NINF_BITS, 32'h3F00_0000, 32'h3F2A_AAAB, 0, 0, 0},
        '{FMT_A2B10G10R10_I, PINF_BITS, 32'h4F00_0000, U1023_BITS, U3_BITS,
          1, 32'hFFFF_FFFF, 3'd4},
        '{FMT_A2B10G10R10_I, 32'h3F00_0000, 32'h3EFF_FFFF, 32'h4420_2000, NAN_BITS, 0, 0, 0},
        '{4'd15, ONE_BITS, ONE_BITS, ONE_BITS, ONE_BITS, 1, 32'h0, 3'd4}
    };

    initial begin
        int phase_len, sent, fmt_pick;
        bit burst;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) begin
            if (directed[i].fmt != cur_fmt) begin
                s_valid <= 1'b0;
                write_format(directed[i].fmt);
            end
            send_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].a,
                       directed[i].fixed, directed[i].word, directed[i].count, 1'b0);
        end
        sent = 0;
        fmt_pick = 0;
        while (sent < NUM_RANDOM) begin
            s_valid <= 1'b0;
            write_format(fmt_pick < 16 ? 4'(fmt_pick) : 4'($urandom_range(0, 15)));
            fmt_pick++;
            phase_len = $urandom_range(30, 90);
            burst = $urandom_range(0, 2) == 0;
            for (int j = 0; j < phase_len && sent < NUM_RANDOM; j++) begin
                if (j == phase_len / 2) begin
                    s_valid <= 1'b0;
                    wait_idle();
                end
                send_pixel(random_channel(), random_channel(), random_channel(),
                           random_channel(), 1'b0, 32'd0, 3'd0, burst);
                sent++;
            end
        end
        s_valid <= 1'b0;
        sender_done = 1'b1;
    end

    initial begin
        int run_len;
        forever begin
            run_len = $urandom_range(0, 5);
            if (run_len > 0) begin
                m_ready <= 1'b0;
                repeat (run_len) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: packed_pixel=%h byte_count=%0d",
                             m_packed_pixel, m_byte_count);
            end else begin
                if (m_packed_pixel !== expected_words[0] ||
                    m_byte_count !== expected_counts[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: packed_pixel exp %h got %h, byte_count exp %0d got %0d",
                                 expected_words[0], m_packed_pixel,
                                 expected_counts[0], m_byte_count);
                end
                void'(expected_words.pop_front());
                void'(expected_counts.pop_front());
            end
        end
    end

    initial begin
        wait (sender_done);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("rgba_float_pixel_packer: match");
        end else begin
            $display("rgba_float_pixel_packer: mismatch");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("rgba_float_pixel_packer: mismatch");
        $finish;
    end

endmodule
